// ===== hw/rtl/jprp_pkg.sv =====
// Shared types and constants for the JTAG pulse run packer.
`default_nettype none

package jprp_pkg;

    localparam int MAX_RUN_DEF = 8;

    // Header flag bits.
    localparam logic [7:0] HDR_TMS_RUN = 8'h80;
    localparam logic [7:0] HDR_TMS_END = 8'h40;

    // Output queue size (power of two).
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       flush;
        logic [1:0] tdo_expect;
        logic [1:0] tdi_code;
        logic       tms;
    } t_pulse;

    typedef struct packed {
        logic       last;
        logic [7:0] compare_mask;
        logic [7:0] expect_bits;
        logic [7:0] shift_bits;
        logic [7:0] header;
    } t_cmd;

    // Up to two commands per pulse, in output order; v1 implies v0.
    typedef struct packed {
        logic v0;
        logic v1;
        t_cmd cmd0;
        t_cmd cmd1;
    } t_pack_out;

endpackage

`default_nettype wire

// ===== hw/rtl/jprp_packer.sv =====
// Run state and packing logic: turns one pulse into zero, one or two commands.
`default_nettype none

module jprp_packer
    import jprp_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_pulse    i_pulse,
    output t_pack_out o_res
);

    localparam int CW = $clog2(MAX_RUN + 1);

    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_is_tms, n_is_tms;
    logic [7:0]    r_shift, n_shift;
    logic [7:0]    r_expect, n_expect;
    logic [7:0]    r_mask, n_mask;

    logic          is_tms;
    logic          split;
    logic          fresh;
    logic [CW-1:0] base_cnt;
    logic [CW-1:0] new_cnt;
    logic [7:0]    bit_sel;
    logic [7:0]    new_shift;
    logic [7:0]    new_expect;
    logic [7:0]    new_mask;
    logic          tms_after;
    logic          close;
    t_cmd          old_cmd;
    t_cmd          new_cmd;

    always_comb begin
        is_tms   = i_pulse.tdi_code[1];
        // A pending run of the other kind is sent out ahead of this pulse.
        split    = (r_cnt != '0) && (r_is_tms != is_tms);
        fresh    = split || (r_cnt == '0);
        base_cnt = fresh ? '0 : r_cnt;
        bit_sel  = 8'(1) << base_cnt;

        new_shift  = (fresh ? 8'h00 : r_shift) |
                     (((is_tms ? i_pulse.tms : i_pulse.tdi_code[0])) ? bit_sel : 8'h00);
        new_mask   = (fresh ? 8'h00 : r_mask) |
                     (!i_pulse.tdo_expect[1] ? bit_sel : 8'h00);
        new_expect = (fresh ? 8'h00 : r_expect) |
                     ((!i_pulse.tdo_expect[1] && i_pulse.tdo_expect[0]) ? bit_sel : 8'h00);
        new_cnt    = base_cnt + CW'(1);

        tms_after = !is_tms && i_pulse.tms;
        close     = (new_cnt >= CW'(MAX_RUN)) || tms_after || i_pulse.flush;

        old_cmd.header       = (r_is_tms ? HDR_TMS_RUN : 8'h00) |
                               8'(3'(r_cnt - CW'(1)));
        old_cmd.shift_bits   = r_shift;
        old_cmd.expect_bits  = r_expect;
        old_cmd.compare_mask = r_mask;
        old_cmd.last         = !close;

        new_cmd.header       = (is_tms ? HDR_TMS_RUN : 8'h00) |
                               (tms_after ? HDR_TMS_END : 8'h00) |
                               8'(3'(base_cnt));
        new_cmd.shift_bits   = new_shift;
        new_cmd.expect_bits  = new_expect;
        new_cmd.compare_mask = new_mask;
        new_cmd.last         = 1'b1;

        o_res.v0   = i_valid && (split || close);
        o_res.v1   = i_valid && split && close;
        o_res.cmd0 = split ? old_cmd : new_cmd;
        o_res.cmd1 = new_cmd;
    end

    always_comb begin
        n_cnt    = r_cnt;
        n_is_tms = r_is_tms;
        n_shift  = r_shift;
        n_expect = r_expect;
        n_mask   = r_mask;
        if (i_valid) begin
            n_cnt    = close ? '0 : new_cnt;
            n_is_tms = is_tms;
            n_shift  = new_shift;
            n_expect = new_expect;
            n_mask   = new_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_is_tms <= 1'b0;
            r_shift  <= 8'h00;
            r_expect <= 8'h00;
            r_mask   <= 8'h00;
        end else begin
            r_cnt    <= n_cnt;
            r_is_tms <= n_is_tms;
            r_shift  <= n_shift;
            r_expect <= n_expect;
            r_mask   <= n_mask;
        end
    end

    a_cnt_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CW'(MAX_RUN))
        else $error("pending run reached the maximum without being sent");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && close |=> r_cnt == '0)
        else $error("run still pending after its command was sent");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |=> $stable(r_cnt) && $stable(r_is_tms))
        else $error("run state changed without a pulse");

endmodule

`default_nettype wire

// ===== hw/rtl/jprp_out_queue.sv =====
// Small command queue that takes up to two commands per cycle and gives one.
`default_nettype none

module jprp_out_queue
    import jprp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push_en,
    input  t_pack_out i_res,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output logic      o_valid,
    output logic      o_room
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, n_wr;
    logic [QUEUE_AW-1:0] r_rd, n_rd;
    logic [QUEUE_CW-1:0] r_count, n_count;
    logic                push0;
    logic                push1;

    always_comb begin
        push0   = i_push_en && i_res.v0;
        push1   = i_push_en && i_res.v1;
        n_wr    = r_wr + QUEUE_AW'(push0) + QUEUE_AW'(push1);
        n_rd    = r_rd + QUEUE_AW'(i_pop);
        n_count = r_count + QUEUE_CW'(push0) + QUEUE_CW'(push1) - QUEUE_CW'(i_pop);
        o_valid = (r_count != '0);
        o_cmd   = r_mem[r_rd];
        // Room for two more, counting the beat leaving this cycle.
        o_room  = r_count <= (QUEUE_CW'(QUEUE_DEPTH - 2) + QUEUE_CW'(i_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
        if (push0) begin
            r_mem[r_wr] <= i_res.cmd0;
        end
        if (push1) begin
            r_mem[r_wr + QUEUE_AW'(1)] <= i_res.cmd1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("command queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_en |-> o_room)
        else $error("commands pushed without room for two");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop && !push0 |=> r_count == $past(r_count) - QUEUE_CW'(1))
        else $error("queue count did not drop on a lone pop");

endmodule

`default_nettype wire

// ===== hw/rtl/jprp_top_dummy_guard.sv =====
// Pulse input register stage: holds one beat until the packer takes it.
`default_nettype none

module jprp_in_stage
    import jprp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_pulse i_pulse,
    input  logic   i_take,
    output logic   o_valid,
    output t_pulse o_pulse
);

    logic   r_valid, n_valid;
    t_pulse r_pulse;

    always_comb begin
        o_ready = !r_valid || i_take;
        n_valid = (i_valid && o_ready) || (r_valid && !i_take);
        o_valid = r_valid;
        o_pulse = r_pulse;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_valid && o_ready) begin
            r_pulse <= i_pulse;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/jtag_pulse_run_packer.sv =====
// Top level of the JTAG pulse run packer: input stage, packer and command queue.
// A command reaches m_axis through the input stage register, then the command queue.
// Throughput: one pulse per cycle while the queue has room for two; a pulse closing two
// runs queues two commands for the single read port of the four-entry command queue.
// Reset: synchronous, active low; clears the pending run, the input stage and the queue.
`default_nettype none

module jtag_pulse_run_packer
    import jprp_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] tms, [2:1] tdi_code, [4:3] tdo_expect
    input  logic        s_axis_tlast,   // flush
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] header, [15:8] shift_bits,
                                        // [23:16] expect_bits, [31:24] compare_mask
    output logic        m_axis_tlast
);

    t_pulse    s_pulse;
    t_pulse    q_pulse;
    logic      q_valid;
    logic      room;
    logic      take;
    t_pack_out res;
    t_cmd      out_cmd;

    always_comb begin
        s_pulse.tms        = s_axis_tdata[0];
        s_pulse.tdi_code   = s_axis_tdata[2:1];
        s_pulse.tdo_expect = s_axis_tdata[4:3];
        s_pulse.flush      = s_axis_tlast;
        take               = q_valid && room;
        m_axis_tdata       = {out_cmd.compare_mask, out_cmd.expect_bits,
                              out_cmd.shift_bits, out_cmd.header};
        m_axis_tlast       = out_cmd.last;
    end

    jprp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pulse (s_pulse),
        .i_take  (take),
        .o_valid (q_valid),
        .o_pulse (q_pulse)
    );

    jprp_packer #(
        .MAX_RUN (MAX_RUN)
    ) u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (take),
        .i_pulse (q_pulse),
        .o_res   (res)
    );

    jprp_out_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (take),
        .i_res     (res),
        .i_pop     (m_axis_tvalid && m_axis_tready),
        .o_cmd     (out_cmd),
        .o_valid   (m_axis_tvalid),
        .o_room    (room)
    );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the JTAG pulse run packer stream interface.
module tb;
    import jprp_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_ERR_SHOW = 10;

    localparam logic [1:0] TDI_LOW      = 2'd0;
    localparam logic [1:0] TDI_HIGH     = 2'd1;
    localparam logic [1:0] TDI_NONE     = 2'd2;
    localparam logic [1:0] TDI_NONE_ALT = 2'd3;
    localparam logic [1:0] TDO_LOW      = 2'd0;
    localparam logic [1:0] TDO_HIGH     = 2'd1;
    localparam logic [1:0] TDO_DC       = 2'd2;
    localparam logic [1:0] TDO_DC_ALT   = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    jtag_pulse_run_packer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pending run as the packer should hold it.
    logic [3:0] run_len;
    logic       run_tms;
    logic [7:0] run_shift;
    logic [7:0] run_expect;
    logic [7:0] run_mask;

    t_cmd cmd_q[$];
    int   err_cnt = 0;
    int   pulse_cnt = 0;
    int   cmd_cnt = 0;
    int   dual_cnt = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   hold_len = 0;
    int   hold_seq = 0;
    int   quiet_cycles = 0;

    function automatic t_cmd close_run(input logic tms_end);
        t_cmd c;
        c.header       = {run_tms, !run_tms && tms_end, 3'b000, 3'(run_len - 4'd1)};
        c.shift_bits   = run_shift;
        c.expect_bits  = run_expect;
        c.compare_mask = run_mask;
        c.last         = 1'b0;
        run_len    = 4'd0;
        run_tms    = 1'b0;
        run_shift  = 8'd0;
        run_expect = 8'd0;
        run_mask   = 8'd0;
        return c;
    endfunction

    function automatic void pack_pulse(input t_pulse p);
        t_cmd       cmds[$];
        logic       is_tms;
        logic       tms_end;
        logic [7:0] bit_sel;
        is_tms = p.tdi_code[1];
        if (run_len != 0 && run_tms != is_tms)
            cmds.push_back(close_run(1'b0));
        if (run_len == 0)
            run_tms = is_tms;
        bit_sel = 8'd1 << run_len[2:0];
        if (is_tms ? p.tms : p.tdi_code[0])
            run_shift = run_shift | bit_sel;
        if (!p.tdo_expect[1]) begin
            run_mask = run_mask | bit_sel;
            if (p.tdo_expect[0])
                run_expect = run_expect | bit_sel;
        end
        run_len = run_len + 4'd1;
        tms_end = !is_tms && p.tms;
        if (run_len >= MAX_RUN_DEF || tms_end || p.flush)
            cmds.push_back(close_run(tms_end));
        if (cmds.size() > 0)
            cmds[cmds.size() - 1].last = 1'b1;
        if (cmds.size() > 1)
            dual_cnt++;
        foreach (cmds[i])
            cmd_q.push_back(cmds[i]);
    endfunction

    function automatic t_pulse mk_pulse(input logic tms, input logic [1:0] tdi,
                                        input logic [1:0] tdo, input logic flush);
        t_pulse p;
        p.tms        = tms;
        p.tdi_code   = tdi;
        p.tdo_expect = tdo;
        p.flush      = flush;
        return p;
    endfunction

    // Offer one pulse beat, with a random gap in front of it, and wait until it is taken.
    task automatic send_pulse(input t_pulse p);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, p.tdo_expect, p.tdi_code, p.tms};
        s_axis_tlast  <= p.flush;
        do @(posedge i_clk); while (!s_axis_tready);
        pack_pulse(p);
        pulse_cnt++;
    endtask

    task automatic drain_commands();
        s_axis_tvalid <= 1'b0;
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed runs with random content; about a fifth of the groups are noise.
    task automatic send_run_groups(input int n_items);
        int     sent;
        int     len;
        logic   noise;
        logic   tms_kind;
        t_pulse p;
        sent = 0;
        while (sent < n_items) begin
            len      = $urandom_range(1, 10);
            noise    = ($urandom_range(99) < 20);
            tms_kind = 1'($urandom_range(1));
            for (int i = 0; i < len && sent < n_items; i++) begin
                if (noise) begin
                    p = t_pulse'(6'($urandom_range(63)));
                end else begin
                    if (tms_kind) begin
                        p.tdi_code = ($urandom_range(9) == 0) ? TDI_NONE_ALT : TDI_NONE;
                        p.tms      = 1'($urandom_range(1));
                    end else begin
                        p.tdi_code = $urandom_range(1) ? TDI_HIGH : TDI_LOW;
                        p.tms      = (i == len - 1) ? ($urandom_range(2) != 0)
                                                    : ($urandom_range(15) == 0);
                    end
                    p.tdo_expect = 2'($urandom_range(3));
                    p.flush      = (i == len - 1) ? ($urandom_range(3) == 0)
                                                  : ($urandom_range(19) == 0);
                end
                send_pulse(p);
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        // Full TMS run: closes on the eighth pulse with every TDO code.
        for (int i = 0; i < 8; i++)
            send_pulse(mk_pulse(i[0], TDI_NONE, 2'(i % 4), 1'b0));
        // TDI run that ends on a pulse with TMS high.
        send_pulse(mk_pulse(1'b0, TDI_HIGH, TDO_HIGH, 1'b0));
        send_pulse(mk_pulse(1'b0, TDI_LOW, TDO_LOW, 1'b0));
        send_pulse(mk_pulse(1'b0, TDI_HIGH, TDO_DC, 1'b0));
        send_pulse(mk_pulse(1'b1, TDI_LOW, TDO_DC_ALT, 1'b0));
        // A pending TMS run is closed by a TDI pulse that itself ends its run.
        send_pulse(mk_pulse(1'b1, TDI_NONE_ALT, TDO_HIGH, 1'b0));
        send_pulse(mk_pulse(1'b1, TDI_HIGH, TDO_LOW, 1'b0));
        // Single-pulse TDI run closed by flush.
        send_pulse(mk_pulse(1'b0, TDI_LOW, TDO_HIGH, 1'b1));
        // Kind switch plus flush on the same pulse.
        send_pulse(mk_pulse(1'b0, TDI_HIGH, TDO_HIGH, 1'b0));
        send_pulse(mk_pulse(1'b0, TDI_HIGH, TDO_DC, 1'b0));
        send_pulse(mk_pulse(1'b0, TDI_LOW, TDO_LOW, 1'b0));
        send_pulse(mk_pulse(1'b1, TDI_NONE, TDO_DC, 1'b1));
        // Full TDI run with TMS low throughout.
        for (int i = 0; i < 8; i++)
            send_pulse(mk_pulse(1'b0, i[1] ? TDI_HIGH : TDI_LOW, 2'((i + 1) % 4), 1'b0));
        drain_commands();
    endtask

    task automatic test_streaming();
        send_idle_pct = 0;  stall_pct = 0;  send_run_groups(160);
        send_idle_pct = 61; stall_pct = 0;  send_run_groups(160);
        send_idle_pct = 0;  stall_pct = 61; send_run_groups(160);
        send_idle_pct = 33; stall_pct = 33; send_run_groups(160);
        drain_commands();
    endtask

    // Output held off for a long stretch while pulses keep coming, so the queue fills.
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_len      = 150;
        hold_seq++;
        send_run_groups(60);
        drain_commands();
    endtask

    // Output side: random stalls, a long hold-off on request, and the command check.
    int   hold_left = 0;
    int   hold_seen = 0;
    t_cmd got_cmd;
    t_cmd want_cmd;

    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left     = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end

        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_cmd = {m_axis_tlast, m_axis_tdata[31:24], m_axis_tdata[23:16],
                       m_axis_tdata[15:8], m_axis_tdata[7:0]};
            cmd_cnt++;
            if (cmd_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_ERR_SHOW)
                    $display("ERROR: unexpected command hdr=%h shift=%h exp=%h mask=%h last=%b",
                             got_cmd.header, got_cmd.shift_bits, got_cmd.expect_bits,
                             got_cmd.compare_mask, got_cmd.last);
            end else begin
                want_cmd = cmd_q.pop_front();
                if (got_cmd.header !== want_cmd.header
                        || got_cmd.shift_bits !== want_cmd.shift_bits
                        || got_cmd.expect_bits !== want_cmd.expect_bits
                        || got_cmd.compare_mask !== want_cmd.compare_mask
                        || got_cmd.last !== want_cmd.last) begin
                    err_cnt++;
                    if (err_cnt <= MAX_ERR_SHOW)
                        $display({"ERROR: command %0d expected hdr=%h shift=%h exp=%h ",
                                  "mask=%h last=%b, got hdr=%h shift=%h exp=%h mask=%h last=%b"},
                                 cmd_cnt, want_cmd.header, want_cmd.shift_bits,
                                 want_cmd.expect_bits, want_cmd.compare_mask, want_cmd.last,
                                 got_cmd.header, got_cmd.shift_bits, got_cmd.expect_bits,
                                 got_cmd.compare_mask, got_cmd.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("ERROR: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        run_len    = 4'd0;
        run_tms    = 1'b0;
        run_shift  = 8'd0;
        run_expect = 8'd0;
        run_mask   = 8'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_streaming();
        test_backpressure();

        $display("Sent %0d pulses and checked %0d commands, %0d pulses closing two runs,",
                 pulse_cnt, cmd_cnt, dual_cnt);
        $display("across idle and stall mixes on both sides and a long output hold-off.");
        if (cmd_q.size() != 0)
            $display("ERROR: %0d expected commands never arrived", cmd_q.size());
        if (err_cnt == 0 && cmd_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
